// File: rtl/rc4ks_pkg.sv
// ----------------------------------------------------------------------------
// rc4ks_pkg
// Shared types, control word layout and microprogram for the RC4 keystream
// cipher: step codes, datapath selects and the read-only control store.
// ----------------------------------------------------------------------------
package rc4ks_pkg;

    // mode codes on the input request
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    // s-box geometry
    localparam int SBOX_DEPTH = 256;

    // microprogram step addresses
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_K4,
        ST_KEND,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_PASS
    } step_t;

    // s-box read address select
    typedef enum logic [2:0] {
        RD_I,   // index i
        RD_N,   // schedule counter
        RD_J,   // index j
        RD_JN,  // j plus current read data
        RD_AR,  // a plus current read data
        RD_T    // latched keystream index
    } rd_sel_t;

    // s-box write address select
    typedef enum logic [1:0] {
        WA_N,
        WA_J,
        WA_I
    } wa_sel_t;

    // s-box write data select
    typedef enum logic [1:0] {
        WD_N,   // identity fill
        WD_A,
        WD_B,
        WD_RD   // current read data
    } wd_sel_t;

    // index j update
    typedef enum logic [1:0] {
        J_HOLD,
        J_CLEAR,
        J_KSA,
        J_PRGA
    } j_op_t;

    // result emission
    typedef enum logic [1:0] {
        EM_NONE,
        EM_PASS,
        EM_KS
    } emit_t;

    // next step condition
    typedef enum logic [2:0] {
        C_NEXT,      // fall through
        C_GOTO,      // unconditional jump
        C_LOOP_N,    // jump to target until the counter wraps
        C_WAIT_OUT,  // hold until the output register is free, then jump
        C_DISPATCH   // decode the incoming request
    } cond_t;

    // one control word
    typedef struct packed {
        logic    accept;
        rd_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        logic    latch_a;
        logic    latch_b;
        logic    latch_t;
        j_op_t   j_op;
        logic    n_inc;
        logic    k_clr;
        logic    k_adv;
        logic    finish;
        emit_t   emit;
        cond_t   cond;
        step_t   target;
    } ctrl_word_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_req;
        logic in_mode;
        logic in_last;
        logic key_valid;
        logic n_last;
        logic out_free;
    } status_t;

    // control store
    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t cw;
        cw        = '0;
        cw.rd_sel = RD_I;
        cw.cond   = C_NEXT;
        cw.target = ST_IDLE;
        case (step)
            ST_IDLE:
            begin
                cw.accept = 1'b1;
                cw.cond   = C_DISPATCH;
            end
            ST_FILL:
            begin
                cw.wr_en  = 1'b1;
                cw.wa_sel = WA_N;
                cw.wd_sel = WD_N;
                cw.n_inc  = 1'b1;
                cw.j_op   = J_CLEAR;
                cw.k_clr  = 1'b1;
                cw.cond   = C_LOOP_N;
                cw.target = ST_FILL;
            end
            ST_K0:
            begin
                cw.rd_sel = RD_N;
            end
            ST_K1:
            begin
                cw.latch_a = 1'b1;
                cw.j_op    = J_KSA;
            end
            ST_K2:
            begin
                cw.rd_sel = RD_J;
            end
            ST_K3:
            begin
                cw.wr_en  = 1'b1;
                cw.wa_sel = WA_N;
                cw.wd_sel = WD_RD;
            end
            ST_K4:
            begin
                cw.wr_en  = 1'b1;
                cw.wa_sel = WA_J;
                cw.wd_sel = WD_A;
                cw.n_inc  = 1'b1;
                cw.k_adv  = 1'b1;
                cw.cond   = C_LOOP_N;
                cw.target = ST_K0;
            end
            ST_KEND:
            begin
                cw.finish = 1'b1;
                cw.cond   = C_GOTO;
                cw.target = ST_IDLE;
            end
            ST_P1:
            begin
                cw.latch_a = 1'b1;
                cw.j_op    = J_PRGA;
                cw.rd_sel  = RD_JN;
            end
            ST_P2:
            begin
                cw.latch_b = 1'b1;
                cw.latch_t = 1'b1;
                cw.wr_en   = 1'b1;
                cw.wa_sel  = WA_J;
                cw.wd_sel  = WD_A;
                cw.rd_sel  = RD_AR;
            end
            ST_P3:
            begin
                cw.wr_en  = 1'b1;
                cw.wa_sel = WA_I;
                cw.wd_sel = WD_B;
                cw.rd_sel = RD_T;
                cw.emit   = EM_KS;
                cw.cond   = C_WAIT_OUT;
                cw.target = ST_IDLE;
            end
            ST_PASS:
            begin
                cw.emit   = EM_PASS;
                cw.cond   = C_WAIT_OUT;
                cw.target = ST_IDLE;
            end
            default:
            begin
                cw.cond   = C_GOTO;
                cw.target = ST_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// File: rtl/rc4_keystream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_keystream_cipher
// RC4 stream cipher with a byte-serial key loader, run by a microcoded
// sequencer over a single s-box memory.
// ----------------------------------------------------------------------------
// Key bytes (tuser = 0) are taken one per cycle while the sequencer is idle
// and stored; bytes beyond MAX_KEY_BYTES are dropped. The key byte with tlast
// set starts the schedule: an identity fill of all 256 s-box entries, then
// 256 swaps, plus one closing step, with the input held off until the
// schedule ends. A data byte (tuser = 1) once keyed runs through the steps
// P1, P2 and P3, which follow the chain of dependent reads and the swap through
// the one read and one write port of the s-box memory; before any key it
// passes through the PASS step with keyed = 0. A new request is taken while a
// finished result still waits in the output register. After reset no
// clearing pass runs.
module rc4_keystream_cipher #(
    parameter int MAX_KEY_BYTES = 256   // 1 to 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] value
    input  logic [0:0] s_axis_tuser,    // [0] mode
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] data_out
    output logic [0:0] m_axis_tuser     // [0] keyed
);
    import rc4ks_pkg::*;

    ctrl_word_t ctrl;
    status_t    status;
    logic       keyed;

    // sequencer
    rc4ks_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // datapath
    rc4ks_dpath #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .in_valid  (s_axis_tvalid),
        .in_mode   (s_axis_tuser[0]),
        .in_value  (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_keyed (keyed)
    );

    assign s_axis_tready = ctrl.accept;
    assign m_axis_tuser  = keyed;

endmodule

// File: rtl/rc4ks_ram.sv
// ----------------------------------------------------------------------------
// rc4ks_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address read and write).
// ----------------------------------------------------------------------------
module rc4ks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/rc4ks_useq.sv
// ----------------------------------------------------------------------------
// rc4ks_useq
// Microcode sequencer: step counter, control store lookup and jump logic.
// ----------------------------------------------------------------------------
module rc4ks_useq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rc4ks_pkg::status_t   status,
    output rc4ks_pkg::ctrl_word_t ctrl
);
    import rc4ks_pkg::*;

    step_t step_reg;
    step_t step_next;

    // control word for the current step
    assign ctrl = ucode(step_reg);

    // next step
    always_comb
    begin
        step_next = step_reg;
        case (ctrl.cond)
            C_NEXT:
            begin
                step_next = step_t'(step_reg + 4'd1);
            end
            C_GOTO:
            begin
                step_next = ctrl.target;
            end
            C_LOOP_N:
            begin
                step_next = status.n_last ? step_t'(step_reg + 4'd1) : ctrl.target;
            end
            C_WAIT_OUT:
            begin
                step_next = status.out_free ? ctrl.target : step_reg;
            end
            C_DISPATCH:
            begin
                if (!status.in_req)
                begin
                    step_next = step_reg;
                end
                else if (status.in_mode == MODE_KEY)
                begin
                    step_next = status.in_last ? ST_FILL : ST_IDLE;
                end
                else
                begin
                    step_next = status.key_valid ? ST_P1 : ST_PASS;
                end
            end
            default:
            begin
                step_next = ST_IDLE;
            end
        endcase
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // schedule end leaves the block keyed
    a_kend_keyed: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == ST_KEND |=> status.key_valid)
        else $error("key not valid after schedule");

    // a delivered keystream result returns to idle
    a_p3_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_P3) && status.out_free |=> step_reg == ST_IDLE)
        else $error("keystream step did not return to idle");

    // loading a key byte without last keeps the sequencer idle
    a_key_byte: assert property (@(posedge clk) disable iff (!rst_n)
        status.in_req && (status.in_mode == MODE_KEY) && !status.in_last
        |=> step_reg == ST_IDLE)
        else $error("plain key byte left idle");

endmodule

// File: rtl/rc4ks_dpath.sv
// ----------------------------------------------------------------------------
// rc4ks_dpath
// Datapath: s-box and key memories, indices, working registers, key loader
// and output register, all steered by the control word.
// ----------------------------------------------------------------------------
module rc4ks_dpath #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rc4ks_pkg::ctrl_word_t ctrl,
    output rc4ks_pkg::status_t    status,
    input  logic                  in_valid,
    input  logic                  in_mode,
    input  logic [7:0]            in_value,
    input  logic                  in_last,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [7:0]            out_data,
    output logic                  out_keyed
);
    import rc4ks_pkg::*;

    // key length above the s-box depth acts as the s-box depth
    localparam int KEY_BYTES = (MAX_KEY_BYTES > SBOX_DEPTH) ? SBOX_DEPTH : MAX_KEY_BYTES;
    localparam int KAW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int KCW = $clog2(KEY_BYTES + 1);
    localparam logic [KCW-1:0] KEY_LIMIT = KCW'(KEY_BYTES);

    // control state
    logic [7:0]     i_reg, i_next;
    logic [7:0]     j_reg, j_next;
    logic [7:0]     n_reg, n_next;
    logic [KAW-1:0] k_reg, k_next;
    logic [KCW-1:0] key_count_reg, key_count_next;
    logic           key_valid_reg, key_valid_next;
    logic           out_valid_reg, out_valid_next;

    // payload
    logic [7:0]     a_reg, b_reg, t_reg, data_reg;
    logic [KCW-1:0] len_reg;
    logic [7:0]     out_data_reg;
    logic           out_keyed_reg;

    // memory ports
    logic [7:0]     s_raddr, s_waddr, s_wdata, s_rdata;
    logic           s_we;
    logic           k_we;
    logic [KAW-1:0] k_waddr;
    logic [7:0]     k_rdata;

    // helpers
    logic           key_req, data_req, in_req, key_room;
    logic [KCW-1:0] count_after, sched_len, k_inc;
    logic [7:0]     jn_sum, ar_sum, ksa_sum, ks_byte;
    logic           out_free, emit_fire, emit_ks;

    rc4ks_ram #(.WIDTH(8), .DEPTH(SBOX_DEPTH)) u_sbox (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    rc4ks_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_key (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (in_value),
        .raddr (k_reg),
        .rdata (k_rdata)
    );

    // request decode and key loader
    assign in_req      = in_valid && ctrl.accept;
    assign key_req     = in_req && (in_mode == MODE_KEY);
    assign data_req    = in_req && (in_mode == MODE_DATA);
    assign key_room    = key_count_reg < KEY_LIMIT;
    assign count_after = key_room ? key_count_reg + KCW'(1) : key_count_reg;
    assign sched_len   = (count_after == '0) ? KCW'(1) : count_after;
    assign k_we        = key_req && key_room;
    assign k_waddr     = key_count_reg[KAW-1:0];

    // index arithmetic
    assign jn_sum  = j_reg + s_rdata;
    assign ar_sum  = a_reg + s_rdata;
    assign ksa_sum = j_reg + s_rdata + k_rdata;
    assign k_inc   = KCW'(k_reg) + KCW'(1);

    // s-box read address
    always_comb
    begin
        case (ctrl.rd_sel)
            RD_I:    s_raddr = i_reg;
            RD_N:    s_raddr = n_reg;
            RD_J:    s_raddr = j_reg;
            RD_JN:   s_raddr = jn_sum;
            RD_AR:   s_raddr = ar_sum;
            RD_T:    s_raddr = t_reg;
            default: s_raddr = i_reg;
        endcase
    end

    // s-box write port
    assign s_we = ctrl.wr_en;
    always_comb
    begin
        case (ctrl.wa_sel)
            WA_N:    s_waddr = n_reg;
            WA_J:    s_waddr = j_reg;
            WA_I:    s_waddr = i_reg;
            default: s_waddr = n_reg;
        endcase
        case (ctrl.wd_sel)
            WD_N:    s_wdata = n_reg;
            WD_A:    s_wdata = a_reg;
            WD_B:    s_wdata = b_reg;
            WD_RD:   s_wdata = s_rdata;
            default: s_wdata = s_rdata;
        endcase
    end

    // keystream byte with forwarding of the two swap writes (i written last)
    always_comb
    begin
        if (t_reg == i_reg)
        begin
            ks_byte = b_reg;
        end
        else if (t_reg == j_reg)
        begin
            ks_byte = a_reg;
        end
        else
        begin
            ks_byte = s_rdata;
        end
    end

    // output handshake
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_fire = (ctrl.emit != EM_NONE) && out_free;
    assign emit_ks   = emit_fire && (ctrl.emit == EM_KS);

    // next control state
    always_comb
    begin
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = ctrl.n_inc ? n_reg + 8'd1 : n_reg;
        k_next         = k_reg;
        key_count_next = key_count_reg;
        key_valid_next = key_valid_reg;
        out_valid_next = out_valid_reg;

        case (ctrl.j_op)
            J_HOLD:  j_next = j_reg;
            J_CLEAR: j_next = '0;
            J_KSA:   j_next = ksa_sum;
            J_PRGA:  j_next = jn_sum;
            default: j_next = j_reg;
        endcase

        if (ctrl.k_clr)
        begin
            k_next = '0;
        end
        else if (ctrl.k_adv)
        begin
            k_next = (k_inc >= len_reg) ? '0 : k_inc[KAW-1:0];
        end

        // key bytes count up; the last one closes the key
        if (key_req)
        begin
            key_count_next = in_last ? '0 : count_after;
        end

        if (ctrl.finish)
        begin
            i_next         = 8'd1;
            j_next         = '0;
            key_valid_next = 1'b1;
        end
        else if (emit_ks)
        begin
            i_next = i_reg + 8'd1;
        end

        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= 8'd1;
            j_reg         <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            key_count_reg <= '0;
            key_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            key_count_reg <= key_count_next;
            key_valid_reg <= key_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        if (ctrl.latch_a)
        begin
            a_reg <= s_rdata;
        end
        if (ctrl.latch_b)
        begin
            b_reg <= s_rdata;
        end
        if (ctrl.latch_t)
        begin
            t_reg <= ar_sum;
        end
        if (data_req)
        begin
            data_reg <= in_value;
        end
        if (key_req && in_last)
        begin
            len_reg <= sched_len;
        end
        if (emit_fire)
        begin
            out_data_reg  <= emit_ks ? (data_reg ^ ks_byte) : data_reg;
            out_keyed_reg <= emit_ks;
        end
    end

    // status to the sequencer
    always_comb
    begin
        status.in_req    = in_req;
        status.in_mode   = in_mode;
        status.in_last   = in_last;
        status.key_valid = key_valid_reg;
        status.n_last    = (n_reg == 8'hff);
        status.out_free  = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_keyed = out_keyed_reg;

    // key count never passes the key limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KEY_LIMIT)
        else $error("key count above limit");

    // keystream results only come from a scheduled s-box
    a_ks_keyed: assert property (@(posedge clk) disable iff (!rst_n)
        emit_ks |-> key_valid_reg)
        else $error("keystream emitted without key");

    // the key index wraps inside a nonempty key
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.k_adv |-> (len_reg != '0) && (KCW'(k_reg) < len_reg))
        else $error("key index outside key length");

endmodule
